// File: rtl/core/mcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_pkg
// Shared sizes, register indexes and item types of the contrast stretch block.
// ----------------------------------------------------------------------------
package mcs_pkg;

	localparam int STORE_DEPTH = 4096;
	localparam int SAMPLE_BITS = 16;

	localparam int ADDR_W  = $clog2(STORE_DEPTH);
	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int LEVEL_W = 8;
	localparam int REG_W   = 2;

	localparam int NUM_W     = SAMPLE_BITS + 10;
	localparam int QUOT_W    = 9;
	localparam int STEP_W    = $clog2(QUOT_W);
	localparam int JQ_DEPTH  = 2;
	localparam int JQ_AW     = $clog2(JQ_DEPTH);
	localparam int JQ_CNT_W  = $clog2(JQ_DEPTH + 1);

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	localparam logic [REG_W-1:0] REG_OUT_LOW  = REG_W'(0);
	localparam logic [REG_W-1:0] REG_OUT_HIGH = REG_W'(1);

	localparam logic [LEVEL_W-1:0] OUT_LOW_RESET  = 8'd0;
	localparam logic [LEVEL_W-1:0] OUT_HIGH_RESET = 8'd255;

	// one drain request with the extremes as they stood when it was taken
	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] sample;
		logic signed [SAMPLE_BITS-1:0] smin;
		logic signed [SAMPLE_BITS-1:0] smax;
		logic                          last;
		logic                          ovf;
	} job_t;

endpackage

// File: rtl/core/mcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_front
// Takes load and drain requests, holds the pixel store, count and extremes,
// and hands each live drain to the job queue with its stored pixel.
// ----------------------------------------------------------------------------
module mcs_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  push,
	output logic                                  full,
	input  logic                                  mode,
	input  logic                                  frame_start,
	input  logic signed [mcs_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                  jq_full,
	output logic                                  jq_push,
	output mcs_pkg::job_t                         jq_data
);
	import mcs_pkg::*;

	logic signed [SAMPLE_BITS-1:0] store_q [STORE_DEPTH];
	logic signed [SAMPLE_BITS-1:0] rd_s1;
	logic [CNT_W-1:0]              count_q;
	logic [CNT_W-1:0]              rp_q;
	logic signed [SAMPLE_BITS-1:0] min_q;
	logic signed [SAMPLE_BITS-1:0] max_q;
	logic                          drop_q;
	logic                          pend_s1;
	logic                          last_s1;
	logic                          ovf_s1;
	logic signed [SAMPLE_BITS-1:0] min_s1;
	logic signed [SAMPLE_BITS-1:0] max_s1;

	logic                          accept;
	logic                          load_go;
	logic                          store_go;
	logic                          drain_go;
	logic [CNT_W-1:0]              base_cnt;
	logic signed [SAMPLE_BITS-1:0] base_min;
	logic signed [SAMPLE_BITS-1:0] base_max;

	assign full     = pend_s1 | jq_full;
	assign accept   = push & ~full;
	assign load_go  = accept & ~mode;
	assign base_cnt = frame_start ? '0 : count_q;
	assign base_min = frame_start ? SAMPLE_MAX : min_q;
	assign base_max = frame_start ? SAMPLE_MIN : max_q;
	assign store_go = load_go & (base_cnt < CNT_W'(STORE_DEPTH));
	assign drain_go = accept & mode & (rp_q < count_q);

	always_ff @(posedge clk) begin
		if (store_go) begin
			store_q[base_cnt[ADDR_W-1:0]] <= sample;
		end
		if (drain_go) begin
			rd_s1 <= store_q[rp_q[ADDR_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			rp_q    <= '0;
			min_q   <= SAMPLE_MAX;
			max_q   <= SAMPLE_MIN;
			drop_q  <= 1'b0;
			pend_s1 <= 1'b0;
			last_s1 <= 1'b0;
			ovf_s1  <= 1'b0;
			min_s1  <= '0;
			max_s1  <= '0;
		end else begin
			pend_s1 <= drain_go;
			if (load_go) begin
				if (frame_start) begin
					rp_q   <= '0;
					drop_q <= 1'b0;
				end
				if (store_go) begin
					count_q <= base_cnt + CNT_W'(1);
					min_q   <= (sample < base_min) ? sample : base_min;
					max_q   <= (sample > base_max) ? sample : base_max;
				end else begin
					count_q <= base_cnt;
					min_q   <= base_min;
					max_q   <= base_max;
					drop_q  <= 1'b1;
				end
			end
			if (drain_go) begin
				rp_q    <= rp_q + CNT_W'(1);
				last_s1 <= (rp_q + CNT_W'(1)) == count_q;
				ovf_s1  <= drop_q;
				min_s1  <= min_q;
				max_s1  <= max_q;
			end
		end
	end

	assign jq_push = pend_s1;
	assign jq_data = '{sample: rd_s1, smin: min_s1, smax: max_s1, last: last_s1, ovf: ovf_s1};

endmodule

// File: rtl/core/mcs_job_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_job_queue
// Short queue of drain jobs between the front and the back.
// ----------------------------------------------------------------------------
module mcs_job_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  mcs_pkg::job_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output mcs_pkg::job_t rd_data,
	output logic          empty
);
	import mcs_pkg::*;

	job_t                mem_q [JQ_DEPTH];
	logic [JQ_AW-1:0]    wr_ptr_q;
	logic [JQ_AW-1:0]    rd_ptr_q;
	logic [JQ_CNT_W-1:0] cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign full    = cnt_q == JQ_CNT_W'(JQ_DEPTH);
	assign empty   = cnt_q == '0;
	assign do_wr   = wr_en & ~full;
	assign do_rd   = rd_en & ~empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : wr_ptr_q + JQ_AW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == JQ_AW'(JQ_DEPTH - 1)) ? '0 : rd_ptr_q + JQ_AW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + JQ_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - JQ_CNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/core/mcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_back
// Maps one drain job to a display level: multiply, offset sum, then, unless the
// span is blank, a restoring divide one quotient bit a cycle, into the result register.
// ----------------------------------------------------------------------------
module mcs_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          jq_empty,
	output logic                          jq_pop,
	input  mcs_pkg::job_t                 job,
	input  logic [mcs_pkg::LEVEL_W-1:0]   out_low,
	input  logic [mcs_pkg::LEVEL_W-1:0]   out_high,
	input  logic                          pop,
	output logic                          empty,
	output logic [mcs_pkg::LEVEL_W-1:0]   pixel,
	output logic                          last,
	output logic                          overflowed
);
	import mcs_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SUM,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t                    state_q;
	logic [SAMPLE_BITS-1:0]    diff_q;
	logic [SAMPLE_BITS-1:0]    span_q;
	logic                      blank_q;
	logic                      last_q;
	logic                      ovf_q;
	logic signed [NUM_W-1:0]   prod_q;
	logic [NUM_W-1:0]          rem_q;
	logic [NUM_W-1:0]          sd_q;
	logic [QUOT_W-1:0]         quot_q;
	logic [STEP_W-1:0]         step_q;
	logic                      res_valid_q;
	logic [LEVEL_W-1:0]        pixel_q;
	logic                      res_last_q;
	logic                      res_ovf_q;

	logic [SAMPLE_BITS:0]      diff_w;
	logic [SAMPLE_BITS:0]      span_w;
	logic [LEVEL_W:0]          delta_w;
	logic signed [LEVEL_W+2:0] level_w;
	logic [LEVEL_W-1:0]        clamp_w;
	logic                      slot_free;

	assign diff_w  = {job.sample[SAMPLE_BITS-1], job.sample} - {job.smin[SAMPLE_BITS-1], job.smin};
	assign span_w  = {job.smax[SAMPLE_BITS-1], job.smax} - {job.smin[SAMPLE_BITS-1], job.smin};
	assign delta_w = {1'b0, out_high} - {1'b0, out_low};

	// quotient carries an offset of 256 that keeps the dividend positive
	assign level_w = $signed({3'b000, out_low}) + $signed({2'b00, quot_q})
	                 - $signed((LEVEL_W + 3)'(256));
	assign clamp_w = level_w[LEVEL_W+2] ? '0 :
	                 (level_w > $signed((LEVEL_W + 3)'(255))) ? LEVEL_W'(255) :
	                 level_w[LEVEL_W-1:0];

	assign slot_free = ~res_valid_q | pop;
	assign jq_pop    = (state_q == ST_IDLE) & ~jq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			diff_q      <= '0;
			span_q      <= '0;
			blank_q     <= 1'b0;
			last_q      <= 1'b0;
			ovf_q       <= 1'b0;
			prod_q      <= '0;
			rem_q       <= '0;
			sd_q        <= '0;
			quot_q      <= '0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
			pixel_q     <= '0;
			res_last_q  <= 1'b0;
			res_ovf_q   <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (!jq_empty) begin
						diff_q  <= diff_w[SAMPLE_BITS-1:0];
						span_q  <= span_w[SAMPLE_BITS-1:0];
						blank_q <= span_w[SAMPLE_BITS] | (span_w == '0);
						last_q  <= job.last;
						ovf_q   <= job.ovf;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q  <= $signed({1'b0, diff_q}) * $signed(delta_w);
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// 2*num + span + 512*span, with divisor 2*span
					rem_q   <= {prod_q[NUM_W-2:0], 1'b0} + NUM_W'({span_q, 9'b0})
					           + NUM_W'(span_q);
					sd_q    <= NUM_W'({span_q, 9'b0});
					quot_q  <= '0;
					step_q  <= '0;
					state_q <= blank_q ? ST_DONE : ST_DIV;
				end
				ST_DIV: begin
					if (rem_q >= sd_q) begin
						rem_q  <= rem_q - sd_q;
						quot_q <= {quot_q[QUOT_W-2:0], 1'b1};
					end else begin
						quot_q <= {quot_q[QUOT_W-2:0], 1'b0};
					end
					sd_q   <= sd_q >> 1;
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(QUOT_W - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (slot_free) begin
						res_valid_q <= 1'b1;
						pixel_q     <= blank_q ? out_low : clamp_w;
						res_last_q  <= last_q;
						res_ovf_q   <= ovf_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign empty      = ~res_valid_q;
	assign pixel      = pixel_q;
	assign last       = res_last_q;
	assign overflowed = res_ovf_q;

endmodule

// File: rtl/core/minmax_contrast_stretch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// minmax_contrast_stretch
// Min-max contrast stretch of one slice to 8-bit display levels.
// ----------------------------------------------------------------------------
// Loads are taken one per cycle while full is low and written straight into
// the pixel store while it has room; full rises for one cycle after every drain
// that finds a stored pixel while the store read completes, and stays high while
// the two-entry job queue is full. Each such drain yields one result through the
// store read, the queue hand-over, the back end's multiply and offset sum and its
// restoring divider; a blank slice skips the divider. The back end takes a new
// job only after writing the last result, and waits before writing while the
// result register still holds a result that has not been popped.
// Drains with nothing left to read yield no result. The store has no reset
// and needs no clearing pass.
// Config registers may only be written while no request is in flight.
module minmax_contrast_stretch (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   mode,
	input  logic                                   frame_start,
	input  logic signed [mcs_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                                   pop,
	output logic                                   empty,
	output logic [mcs_pkg::LEVEL_W-1:0]            pixel,
	output logic                                   last,
	output logic                                   overflowed,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [mcs_pkg::REG_W-1:0]              cfg_index,
	input  logic [mcs_pkg::LEVEL_W-1:0]            cfg_data
);
	import mcs_pkg::*;

	logic [LEVEL_W-1:0] out_low_q;
	logic [LEVEL_W-1:0] out_high_q;
	logic               jq_push;
	logic               jq_full;
	logic               jq_pop;
	logic               jq_empty;
	job_t               jq_wr;
	job_t               jq_rd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_low_q  <= OUT_LOW_RESET;
			out_high_q <= OUT_HIGH_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_OUT_LOW) begin
				out_low_q <= cfg_data;
			end
			if (cfg_index == REG_OUT_HIGH) begin
				out_high_q <= cfg_data;
			end
		end
	end

	mcs_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.mode        (mode),
		.frame_start (frame_start),
		.sample      (sample),
		.jq_full     (jq_full),
		.jq_push     (jq_push),
		.jq_data     (jq_wr)
	);

	mcs_job_queue u_jq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (jq_push),
		.wr_data (jq_wr),
		.full    (jq_full),
		.rd_en   (jq_pop),
		.rd_data (jq_rd),
		.empty   (jq_empty)
	);

	mcs_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.jq_empty   (jq_empty),
		.jq_pop     (jq_pop),
		.job        (jq_rd),
		.out_low    (out_low_q),
		.out_high   (out_high_q),
		.pop        (pop),
		.empty      (empty),
		.pixel      (pixel),
		.last       (last),
		.overflowed (overflowed)
	);

endmodule

// File: rtl/core/mcs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mcs_checker
// Port-level checks of the contrast stretch block, bound to the top level.
// ----------------------------------------------------------------------------
module mcs_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   push,
	input logic                                   full,
	input logic                                   mode,
	input logic                                   frame_start,
	input logic signed [mcs_pkg::SAMPLE_BITS-1:0] sample,
	input logic                                   pop,
	input logic                                   empty,
	input logic [mcs_pkg::LEVEL_W-1:0]            pixel,
	input logic                                   last,
	input logic                                   overflowed,
	input logic                                   cfg_valid,
	input logic                                   cfg_ready,
	input logic [mcs_pkg::REG_W-1:0]              cfg_index,
	input logic [mcs_pkg::LEVEL_W-1:0]            cfg_data
);
	import mcs_pkg::*;

	logic [LEVEL_W-1:0] lo_q;
	logic [LEVEL_W-1:0] hi_q;
	logic               load_req;

	assign load_req = push & ~full & ~mode;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= OUT_LOW_RESET;
			hi_q <= OUT_HIGH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_OUT_LOW) begin
				lo_q <= cfg_data;
			end
			if (cfg_index == REG_OUT_HIGH) begin
				hi_q <= cfg_data;
			end
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(pixel) && $stable(last) && $stable(overflowed))
		else $error("result changed while waiting");

	a_free_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_req |=> !full)
		else $error("input blocked right after a load request");

	a_known_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !$isunknown({pixel, last, overflowed}))
		else $error("unknown bits on a waiting result");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> ((pixel >= lo_q && pixel <= hi_q) || (pixel >= hi_q && pixel <= lo_q)))
		else $error("pixel outside output levels");

endmodule

bind minmax_contrast_stretch mcs_checker u_mcs_checker (.*);
